FILE: rtl/lsd_counting_radix_sort_core_macros.svh
// ----------------------------------------------------------------------------
// LSD radix sort assertion macros
// Shorthand for clocked assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef LSD_COUNTING_RADIX_SORT_CORE_MACROS_SVH
`define LSD_COUNTING_RADIX_SORT_CORE_MACROS_SVH

// Same-cycle implication.
`define LCRS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lcrs assertion failed");

// Next-cycle implication.
`define LCRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lcrs assertion failed");

`endif

FILE: rtl/lcrs_pkg.sv
// ----------------------------------------------------------------------------
// LSD radix sort package
// Shared widths, constants, datapath operations and sequencer status.
// ----------------------------------------------------------------------------
package lcrs_pkg;

  localparam int unsigned KeyW        = 64;
  localparam int unsigned CfgW        = 4;
  localparam int unsigned DigitW      = 8;
  localparam int unsigned NumDigits   = 256;
  localparam int unsigned PassW       = 3;
  localparam int unsigned MaxKeyBytes = 8;
  localparam int unsigned MaxItemsDef = 64;
  localparam logic [CfgW-1:0] KeyLenReset = 4'd8;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_PASS_INIT,
    OP_CNT_A,
    OP_CNT_B,
    OP_PFX_INIT,
    OP_PFX,
    OP_SCAT_INIT,
    OP_SCAT_A,
    OP_SCAT_B,
    OP_NEXT,
    OP_EMIT_INIT,
    OP_EMIT
  } lcrs_op_e;

  typedef struct packed {
    logic last_seen;
    logic keys_done;
    logic table_done;
    logic passes_done;
    logic batch_done;
  } lcrs_stat_t;

endpackage

FILE: rtl/lcrs_if.sv
// ----------------------------------------------------------------------------
// LSD radix sort channel interfaces
// Valid/ready channels for keys in, sorted keys out, and configuration.
// ----------------------------------------------------------------------------
interface lcrs_in_if;
  import lcrs_pkg::*;
  logic            valid;
  logic            ready;
  logic [KeyW-1:0] key;
  logic            last;
  modport source (output valid, output key, output last, input ready);
  modport sink (input valid, input key, input last, output ready);
endinterface

interface lcrs_out_if;
  import lcrs_pkg::*;
  logic            valid;
  logic            ready;
  logic [KeyW-1:0] sorted_key;
  logic            last_res;
  logic            overflow;
  modport source (output valid, output sorted_key, output last_res, output overflow,
                  input ready);
  modport sink (input valid, input sorted_key, input last_res, input overflow,
                output ready);
endinterface

interface lcrs_cfg_if;
  import lcrs_pkg::*;
  logic            valid;
  logic            ready;
  logic [CfgW-1:0] key_length;
  modport source (output valid, output key_length, input ready);
  modport sink (input valid, input key_length, output ready);
endinterface

FILE: rtl/lsd_counting_radix_sort_core.sv
// ----------------------------------------------------------------------------
// LSD counting radix sort core
// Keys are loaded one beat per cycle until a beat marked last arrives. The
// core then sorts the batch of n stored keys stably, one pass per key byte
// from the least significant byte up, and returns them in ascending order,
// one beat per cycle while the output is taken. In each pass every key does
// a read-modify-write of the 256-entry count memory to count digits and
// another to scatter, and a prefix walk over that memory lies between them.
// No input is taken from the last beat until the final sorted beat has
// entered the output register. Keys beyond MAX_ITEMS are dropped and flagged
// on every result of the batch. The user must write the key length register
// only while the core is idle; the core itself does not enforce this.
// ----------------------------------------------------------------------------
module lsd_counting_radix_sort_core #(
  parameter int unsigned MAX_ITEMS = lcrs_pkg::MaxItemsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lcrs_in_if.sink    in_i,
  lcrs_out_if.source out_o,
  lcrs_cfg_if.sink   cfg_i
);
  import lcrs_pkg::*;

  localparam int unsigned IdxW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);

  lcrs_op_e   op;
  lcrs_stat_t stat;

  logic [CfgW-1:0]   key_length_q, len_q, len_next;
  logic [CntW-1:0]   item_cnt_q, i_q, i_d, i_inc, acc_q;
  logic              drop_q, sel_q;
  logic [DigitW-1:0] b_q, digit, digit_q;
  logic [PassW-1:0]  p_q;
  logic [NumDigits-1:0] cnt_vld_q;

  logic [KeyW-1:0]   store_a_mem [MAX_ITEMS];
  logic [KeyW-1:0]   store_b_mem [MAX_ITEMS];
  logic [CntW-1:0]   cnt_mem [NumDigits];

  logic [KeyW-1:0]   rd_a_q, rd_b_q, key_rd, hold_q;
  logic [CntW-1:0]   cnt_rd_q, cnt_eff, cnt_wd;
  logic              cnt_rv_q, cnt_we;
  logic [DigitW-1:0] cnt_ra, cnt_wa;

  logic              wa_en, wb_en;
  logic [IdxW-1:0]   w_addr;
  logic [KeyW-1:0]   w_data;

  logic              in_fire, room, res_free, emit_load, emit_last;
  logic              out_valid_q, out_last_q, out_ovf_q;
  logic [KeyW-1:0]   out_key_q;

  lcrs_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .op_o   (op)
  );

  assign in_i.ready  = (op == OP_LOAD);
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign room        = (item_cnt_q < CntW'(MAX_ITEMS));

  assign key_rd    = sel_q ? rd_b_q : rd_a_q;
  assign digit     = key_rd[{p_q, 3'b000} +: DigitW];
  assign cnt_eff   = cnt_rv_q ? cnt_rd_q : '0;
  assign i_inc     = i_q + CntW'(1);
  assign res_free  = !out_valid_q || out_o.ready;
  assign emit_load = (op == OP_EMIT) && res_free;
  assign emit_last = (i_inc == item_cnt_q);

  always_comb begin
    if (key_length_q == '0) begin
      len_next = CfgW'(1);
    end else if (key_length_q > CfgW'(MaxKeyBytes)) begin
      len_next = CfgW'(MaxKeyBytes);
    end else begin
      len_next = key_length_q;
    end
  end

  always_comb begin
    stat.last_seen   = in_fire && in_i.last;
    stat.keys_done   = (i_q == item_cnt_q);
    stat.table_done  = (b_q == DigitW'(NumDigits - 1));
    stat.passes_done = ((CfgW'(p_q) + CfgW'(1)) == len_q);
    stat.batch_done  = emit_load && emit_last;
  end

  always_comb begin
    i_d    = i_q;
    cnt_ra = digit;
    cnt_we = 1'b0;
    cnt_wa = digit_q;
    cnt_wd = cnt_eff + CntW'(1);
    wa_en  = 1'b0;
    wb_en  = 1'b0;
    w_addr = cnt_eff[IdxW-1:0];
    w_data = hold_q;
    case (op)
      OP_LOAD: begin
        wa_en  = in_fire && room;
        w_addr = item_cnt_q[IdxW-1:0];
        w_data = in_i.key;
      end
      OP_PASS_INIT, OP_SCAT_INIT, OP_EMIT_INIT: begin
        i_d = '0;
      end
      OP_CNT_A, OP_SCAT_A: begin
        i_d = i_inc;
      end
      OP_CNT_B: begin
        cnt_we = 1'b1;
      end
      OP_PFX_INIT: begin
        cnt_ra = '0;
      end
      OP_PFX: begin
        cnt_ra = b_q + DigitW'(1);
        cnt_we = 1'b1;
        cnt_wa = b_q;
        cnt_wd = acc_q;
      end
      OP_SCAT_B: begin
        cnt_we = 1'b1;
        wa_en  = sel_q;
        wb_en  = !sel_q;
      end
      OP_EMIT: begin
        if (emit_load) begin
          i_d = i_inc;
        end
      end
      default: begin
        i_d = i_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= KeyLenReset;
      len_q        <= KeyLenReset;
      item_cnt_q   <= '0;
      drop_q       <= 1'b0;
      i_q          <= '0;
      b_q          <= '0;
      acc_q        <= '0;
      p_q          <= '0;
      sel_q        <= 1'b0;
      cnt_vld_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        key_length_q <= cfg_i.key_length;
      end
      i_q <= i_d;
      case (op)
        OP_LOAD: begin
          if (in_fire) begin
            if (room) begin
              item_cnt_q <= item_cnt_q + CntW'(1);
            end else begin
              drop_q <= 1'b1;
            end
            if (in_i.last) begin
              len_q <= len_next;
              sel_q <= 1'b0;
              p_q   <= '0;
            end
          end
        end
        OP_PASS_INIT: begin
          cnt_vld_q <= '0;
        end
        OP_PFX_INIT: begin
          b_q   <= '0;
          acc_q <= '0;
        end
        OP_PFX: begin
          b_q   <= b_q + DigitW'(1);
          acc_q <= acc_q + cnt_eff;
        end
        OP_NEXT: begin
          p_q   <= p_q + PassW'(1);
          sel_q <= !sel_q;
        end
        OP_EMIT: begin
          if (emit_load && emit_last) begin
            item_cnt_q <= '0;
            drop_q     <= 1'b0;
          end
        end
        default: begin
        end
      endcase
      if (cnt_we) begin
        cnt_vld_q[cnt_wa] <= 1'b1;
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= store_a_mem[i_d[IdxW-1:0]];
    if (wa_en) begin
      store_a_mem[w_addr] <= w_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_b_q <= store_b_mem[i_d[IdxW-1:0]];
    if (wb_en) begin
      store_b_mem[w_addr] <= w_data;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_rd_q <= cnt_mem[cnt_ra];
    cnt_rv_q <= cnt_vld_q[cnt_ra];
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op == OP_CNT_A || op == OP_SCAT_A) begin
      digit_q <= digit;
      hold_q  <= key_rd;
    end
    if (emit_load) begin
      out_key_q  <= key_rd;
      out_last_q <= emit_last;
      out_ovf_q  <= drop_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sorted_key = out_key_q;
  assign out_o.last_res   = out_last_q;
  assign out_o.overflow   = out_ovf_q;

endmodule

FILE: rtl/lcrs_seq.sv
// ----------------------------------------------------------------------------
// LSD radix sort microsequencer
// Step counter over a read-only microprogram with conditional jumps.
// ----------------------------------------------------------------------------
module lcrs_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lcrs_pkg::lcrs_stat_t stat_i,
  output lcrs_pkg::lcrs_op_e   op_o
);
  import lcrs_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD,
    S_PASS,
    S_CNT_A,
    S_CNT_B,
    S_PFX0,
    S_PFX,
    S_SC0,
    S_SC_A,
    S_SC_B,
    S_NEXT,
    S_EM0,
    S_EMIT
  } step_e;

  typedef enum logic [2:0] {
    CS_ALWAYS,
    CS_LAST,
    CS_KEYS_DONE,
    CS_TABLE_DONE,
    CS_PASSES_DONE,
    CS_BATCH_DONE
  } cond_e;

  typedef struct packed {
    lcrs_op_e op;
    cond_e    cond;
    step_e    tgt_t;
    step_e    tgt_f;
  } ucode_t;

  function automatic ucode_t rom(input step_e s);
    ucode_t w;
    case (s)
      S_LOAD:  w = '{OP_LOAD,      CS_LAST,        S_PASS,  S_LOAD};
      S_PASS:  w = '{OP_PASS_INIT, CS_ALWAYS,      S_CNT_A, S_CNT_A};
      S_CNT_A: w = '{OP_CNT_A,     CS_ALWAYS,      S_CNT_B, S_CNT_B};
      S_CNT_B: w = '{OP_CNT_B,     CS_KEYS_DONE,   S_PFX0,  S_CNT_A};
      S_PFX0:  w = '{OP_PFX_INIT,  CS_ALWAYS,      S_PFX,   S_PFX};
      S_PFX:   w = '{OP_PFX,       CS_TABLE_DONE,  S_SC0,   S_PFX};
      S_SC0:   w = '{OP_SCAT_INIT, CS_ALWAYS,      S_SC_A,  S_SC_A};
      S_SC_A:  w = '{OP_SCAT_A,    CS_ALWAYS,      S_SC_B,  S_SC_B};
      S_SC_B:  w = '{OP_SCAT_B,    CS_KEYS_DONE,   S_NEXT,  S_SC_A};
      S_NEXT:  w = '{OP_NEXT,      CS_PASSES_DONE, S_EM0,   S_PASS};
      S_EM0:   w = '{OP_EMIT_INIT, CS_ALWAYS,      S_EMIT,  S_EMIT};
      S_EMIT:  w = '{OP_EMIT,      CS_BATCH_DONE,  S_LOAD,  S_EMIT};
      default: w = '{OP_LOAD,      CS_ALWAYS,      S_LOAD,  S_LOAD};
    endcase
    return w;
  endfunction

  step_e  pc_q, pc_d;
  ucode_t word;
  logic   take;

  always_comb begin
    word = rom(pc_q);
    case (word.cond)
      CS_ALWAYS:      take = 1'b1;
      CS_LAST:        take = stat_i.last_seen;
      CS_KEYS_DONE:   take = stat_i.keys_done;
      CS_TABLE_DONE:  take = stat_i.table_done;
      CS_PASSES_DONE: take = stat_i.passes_done;
      CS_BATCH_DONE:  take = stat_i.batch_done;
      default:        take = 1'b1;
    endcase
    pc_d = take ? word.tgt_t : word.tgt_f;
  end

  assign op_o = word.op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_LOAD;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

FILE: rtl/lcrs_checker.sv
// ----------------------------------------------------------------------------
// LSD radix sort port checker
// Checks input gating and output hold behavior seen at the core's ports.
// ----------------------------------------------------------------------------
`include "lsd_counting_radix_sort_core_macros.svh"

module lcrs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      in_last_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic                      out_last_i,
  input logic [lcrs_pkg::KeyW-1:0] out_key_i
);

  `LCRS_ASSERT_NEXT(a_last_closes_input, clk_i, rst_ni, in_valid_i && in_ready_i && in_last_i, !in_ready_i)
  `LCRS_ASSERT_IMP(a_emit_blocks_input, clk_i, rst_ni, out_valid_i && !out_last_i, !in_ready_i)
  `LCRS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_key_i) && $stable(out_last_i))

endmodule

bind lsd_counting_radix_sort_core lcrs_checker u_lcrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_last_i  (out_o.last_res),
  .out_key_i   (out_o.sorted_key)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSD counting radix sort core testbench
// Streams batches of keys into the core under fixed and random key length
// settings and checks each sorted beat against a stable software sort of the same batch.
// Random gaps on both channels, one long output hold-off and batches beyond
// capacity exercise backpressure and the overflow flag.
// ----------------------------------------------------------------------------
module testbench;
  import lcrs_pkg::*;

  localparam int unsigned CAPACITY     = MaxItemsDef;
  localparam int unsigned IDLE_PCT     = 22;
  localparam int unsigned HOLD_CYCLES  = 700;
  localparam int unsigned SETTLE       = 32;
  localparam int unsigned DRAIN_CYCLES = 4300;
  localparam int unsigned RANDOM_ITEMS = 380;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            last;
  } key_beat_t;

  typedef struct packed {
    logic [KeyW-1:0] sorted_key;
    logic            last_res;
    logic            overflow;
  } sorted_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lcrs_in_if  key_if ();
  lcrs_out_if sorted_if ();
  lcrs_cfg_if cfg_if ();

  lsd_counting_radix_sort_core #(
    .MAX_ITEMS(CAPACITY)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (key_if),
    .out_o (sorted_if),
    .cfg_i (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  key_beat_t    pending_q[$];
  sorted_beat_t sorted_beats_q[$];

  logic [KeyW-1:0] stored_keys[CAPACITY];
  int unsigned     stored_count  = 0;
  logic            dropped_flag  = 1'b0;
  logic [CfgW-1:0] key_len_model = KeyLenReset;

  logic        beat_pending = 1'b0;
  logic        no_gaps      = 1'b0;
  logic        hold_arm     = 1'b0;
  logic        hold_done    = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned cycle_count  = 0;

  int unsigned mismatches     = 0;
  int unsigned beats_checked  = 0;
  int unsigned keys_accepted  = 0;
  int unsigned batches_sorted = 0;
  int unsigned batches_over   = 0;
  int unsigned cfg_writes     = 0;
  int unsigned random_items   = 0;

  task automatic record_key(input logic [KeyW-1:0] k, input logic is_last);
    logic [KeyW-1:0] order[CAPACITY];
    logic [KeyW-1:0] mask;
    logic [KeyW-1:0] held;
    int unsigned     len;
    int              i;
    int              j;
    if (stored_count < CAPACITY) begin
      stored_keys[stored_count] = k;
      stored_count++;
    end else begin
      dropped_flag = 1'b1;
    end
    if (is_last) begin
      len = key_len_model;
      if (len < 1) len = 1;
      if (len > MaxKeyBytes) len = MaxKeyBytes;
      mask = (len == MaxKeyBytes) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
      // A stable sort on the used bytes gives the same order as the radix passes.
      for (i = 0; i < int'(stored_count); i++) begin
        held = stored_keys[i];
        j = i - 1;
        while (j >= 0 && (order[j] & mask) > (held & mask)) begin
          order[j + 1] = order[j];
          j--;
        end
        order[j + 1] = held;
      end
      for (i = 0; i < int'(stored_count); i++) begin
        sorted_beats_q.insert(sorted_beats_q.size(),
                              '{sorted_key: order[i],
                                last_res: (i == int'(stored_count) - 1),
                                overflow: dropped_flag});
      end
      batches_sorted++;
      if (dropped_flag) batches_over++;
      stored_count = 0;
      dropped_flag = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    key_beat_t nxt;
    if (!rst_ni) begin
      key_if.valid <= 1'b0;
      key_if.key   <= '0;
      key_if.last  <= 1'b0;
    end else begin
      if (key_if.valid && key_if.ready) begin
        record_key(key_if.key, key_if.last);
        keys_accepted++;
        beat_pending = 1'b0;
      end
      if (!beat_pending) begin
        if (pending_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = pending_q.pop_front();
          key_if.valid <= 1'b1;
          key_if.key   <= nxt.key;
          key_if.last  <= nxt.last;
          beat_pending = 1'b1;
        end else begin
          key_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done && sorted_if.valid) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    sorted_beat_t want;
    if (!rst_ni) begin
      sorted_if.ready <= 1'b0;
    end else begin
      if (sorted_if.valid && sorted_if.ready) begin
        if (sorted_beats_q.size() == 0) begin
          $error("sorted beat with no batch waiting: sorted_key %h", sorted_if.sorted_key);
          mismatches++;
        end else begin
          want = sorted_beats_q.pop_front();
          beats_checked++;
          if (sorted_if.sorted_key !== want.sorted_key) begin
            $error("sorted_key: expected %h, actual %h", want.sorted_key,
                   sorted_if.sorted_key);
            mismatches++;
          end
          if (sorted_if.last_res !== want.last_res) begin
            $error("last_res: expected %b, actual %b", want.last_res, sorted_if.last_res);
            mismatches++;
          end
          if (sorted_if.overflow !== want.overflow) begin
            $error("overflow: expected %b, actual %b", want.overflow, sorted_if.overflow);
            mismatches++;
          end
        end
      end
      sorted_if.ready <= (hold_left == 0) && (no_gaps || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [KeyW-1:0] random_key();
    logic [KeyW-1:0] k;
    int unsigned     b;
    k = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: begin
      end
      1: begin
        for (b = 0; b < MaxKeyBytes; b++) k[8 * b +: 8] = 8'($urandom_range(0, 3));
      end
      2: begin
        for (b = 0; b < MaxKeyBytes; b++) k[8 * b +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default: begin
        k[15:0] = 16'($urandom_range(0, 2));
      end
    endcase
    return k;
  endfunction

  task automatic queue_key(input logic [KeyW-1:0] k, input logic is_last);
    pending_q.insert(pending_q.size(), '{key: k, last: is_last});
  endtask

  task automatic queue_batch(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) queue_key(random_key(), i == n - 1);
    random_items += n;
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || beat_pending || sorted_beats_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_key_length(input logic [CfgW-1:0] v);
    wait_idle();
    cfg_if.valid      <= 1'b1;
    cfg_if.key_length <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid  <= 1'b0;
    key_len_model = v;
    cfg_writes++;
  endtask

  initial begin
    int unsigned n;
    int unsigned b;
    key_if.valid      = 1'b0;
    key_if.key        = '0;
    key_if.last       = 1'b0;
    sorted_if.ready   = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.key_length = '0;
    rst_ni            = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    queue_key(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    queue_key(64'h0000_0000_0000_0000, 1'b0);
    queue_key(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    queue_key(64'h8000_0000_0000_0000, 1'b0);
    queue_key(64'h0000_0000_0000_0001, 1'b0);
    queue_key(64'h00FF_00FF_00FF_00FF, 1'b0);
    queue_key(64'h0000_0000_0000_0000, 1'b0);
    queue_key(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);

    write_key_length(4'd0);
    queue_key(64'hA5A5_0000_0000_0003, 1'b0);
    queue_key(64'h1111_2222_3333_4401, 1'b0);
    queue_key(64'hFFFF_FFFF_FFFF_FF03, 1'b0);
    queue_key(64'h0000_0000_0000_0080, 1'b0);
    queue_key(64'h1234_5678_9ABC_DE01, 1'b1);

    write_key_length(4'd15);
    queue_key(64'h0102_0304_0506_0708, 1'b0);
    queue_key(64'h0807_0605_0403_0201, 1'b0);
    queue_key(64'h0102_0304_0506_0709, 1'b0);
    queue_key(64'h0000_0000_0000_00FF, 1'b1);

    write_key_length(4'd2);
    queue_key(64'hDEAD_BEEF_0000_1234, 1'b0);
    queue_key(64'h0000_0000_0000_1234, 1'b0);
    queue_key(64'hCAFE_0000_0000_12FF, 1'b0);
    queue_key(64'h1111_1111_1111_0000, 1'b0);
    queue_key(64'h0000_0000_0000_FFFF, 1'b1);

    // A full store, then a batch whose final two keys, the last one among
    // them, are dropped.
    write_key_length(4'd1);
    queue_batch(CAPACITY);
    write_key_length(4'd8);
    queue_batch(CAPACITY + 2);

    // The output is held off while further batches wait at the input.
    write_key_length(4'd8);
    hold_arm <= 1'b1;
    for (b = 0; b < 3; b++) queue_batch(12);

    write_key_length(4'd5);
    no_gaps <= 1'b1;
    queue_batch(10);
    queue_batch(10);
    wait_idle();
    no_gaps <= 1'b0;

    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 4))
        0:       write_key_length(4'd0);
        1:       write_key_length(4'd15);
        2:       write_key_length(4'd8);
        default: write_key_length(4'($urandom_range(0, 15)));
      endcase
      for (b = $urandom_range(1, 3); b > 0 && random_items < RANDOM_ITEMS; b--) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        queue_batch(n);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sorted %0d batches from %0d key beats, %0d of them past capacity.",
             batches_sorted, keys_accepted, batches_over);
    $display("Checked %0d sorted beats across %0d key length writes.", beats_checked,
             cfg_writes);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/lcrs_pkg.sv
rtl/lcrs_if.sv
rtl/lcrs_seq.sv
rtl/lsd_counting_radix_sort_core.sv
rtl/lcrs_checker.sv
test/testbench.sv
